// File: sv/n_queens_solution_enumerator_top_macros.svh
// Assertion macros shared by the N-queens enumerator modules.
`ifndef N_QUEENS_SOLUTION_ENUMERATOR_TOP_MACROS_SVH
`define N_QUEENS_SOLUTION_ENUMERATOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define NQSE_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("nqse assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define NQSE_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("nqse assertion failed");

`endif

// File: sv/nqse_pkg.sv
// Shared types and constants of the N-queens enumerator.
package nqse_pkg;

  localparam int BS_W       = 4;
  localparam int PLACE_W    = 40;
  localparam int FIELD_W    = 4;
  localparam int COUNT_W    = 10;
  localparam int PACK_ROWS  = PLACE_W / FIELD_W;

  localparam logic [BS_W-1:0]    BS_RESET  = 4'd10;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;

  typedef struct packed {
    logic restart;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [PLACE_W-1:0] placement;
    logic [COUNT_W-1:0] solution_count;
  } rsp_t;

  typedef struct packed {
    logic [BS_W-1:0] board_size;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic start;
    logic advance;
    logic step;
    logic load_out;
    logic res_found;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;
    logic dead;
  } sts_t;

endpackage

// File: sv/nqse_chan.sv
// Valid/ready channel interface carrying one payload per transaction.
interface nqse_chan #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/n_queens_solution_enumerator_top.sv
// Top level of the N-queens solution enumerator.
// Each request transaction either restarts the search (restart = 1, or the
// first request after reset) or asks for the next solution in lexicographic
// order; each gives one response with the found flag, the packed columns
// (4 bits per row, row 0 lowest) and the saturating solution count. The search
// datapath makes one move per clock while it searches: it tests one column of the
// current row against column and diagonal occupancy masks, places a queen, or
// backs up one row. The time per request is data dependent and grows where the
// search backs up far; a request after exhaustion answers without a search.
// board_size is latched at each start; the request channel is ready again as
// soon as a result sits in the response register, whether or not it has been
// taken.
module n_queens_solution_enumerator_top #(
  parameter int MAX_N = 10
) (
  input  logic            clk,
  input  logic            rst,
  nqse_chan.sink          req,
  nqse_chan.source        rsp,
  nqse_chan.sink          cfg
);

  nqse_pkg::cmd_t cmd;
  nqse_pkg::sts_t sts;

  assign cfg.ready = 1'b1;

  nqse_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_restart (req.data.restart),
    .in_ready   (req.ready),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  nqse_dp #(
    .MAX_N (MAX_N)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg.valid),
    .cfg_board_size (cfg.data.board_size),
    .cmd            (cmd),
    .sts            (sts),
    .rsp_found      (rsp.data.found),
    .rsp_placement  (rsp.data.placement),
    .rsp_count      (rsp.data.solution_count)
  );

endmodule

// File: sv/nqse_dp.sv
// Datapath: state, occupancy masks, one step per cycle on cmd.step, result register.
`include "n_queens_solution_enumerator_top_macros.svh"

module nqse_dp #(
  parameter int MAX_N = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [nqse_pkg::BS_W-1:0]     cfg_board_size,
  input  nqse_pkg::cmd_t                cmd,
  output nqse_pkg::sts_t                sts,
  output logic                          rsp_found,
  output logic [nqse_pkg::PLACE_W-1:0]  rsp_placement,
  output logic [nqse_pkg::COUNT_W-1:0]  rsp_count
);

  localparam int NW    = $clog2(MAX_N + 1);
  localparam int RW    = (MAX_N > 2) ? $clog2(MAX_N) : 1;
  localparam int DW    = $clog2(2 * MAX_N + 1);
  localparam int NPACK = (MAX_N < nqse_pkg::PACK_ROWS) ? MAX_N : nqse_pkg::PACK_ROWS;

  logic [nqse_pkg::BS_W-1:0]    board_size;
  logic [NW-1:0]                act_n;
  logic [NW-1:0]                eff_n;
  logic [RW-1:0]                row;
  logic [NW-1:0]                cur_col;
  logic [NW-1:0]                col_of [MAX_N];
  logic [MAX_N:0]               cols;
  logic [2*MAX_N:0]             dsum;
  logic [2*MAX_N:0]             ddif;
  logic [nqse_pkg::COUNT_W-1:0] count;

  logic [RW-1:0]                prev_row;
  logic [NW-1:0]                prev_col;
  logic [DW-1:0]                sidx, didx, psidx, pdidx;
  logic [NW-1:0]                last_row;
  logic                         over, safe;
  logic [nqse_pkg::PLACE_W-1:0] packed_place;

  always_comb begin
    if (board_size == '0) begin
      eff_n = NW'(1);
    end else if (board_size > nqse_pkg::BS_W'(MAX_N)) begin
      eff_n = NW'(MAX_N);
    end else begin
      eff_n = NW'(board_size);
    end
  end

  assign prev_row = row - RW'(1);
  assign prev_col = col_of[prev_row];
  assign sidx     = DW'(row) + DW'(cur_col);
  assign didx     = DW'(row) + DW'(MAX_N) - DW'(cur_col);
  assign psidx    = DW'(prev_row) + DW'(prev_col);
  assign pdidx    = DW'(prev_row) + DW'(MAX_N) - DW'(prev_col);
  assign last_row = act_n - NW'(1);
  assign over     = cur_col >= act_n;
  assign safe     = !cols[cur_col] && !dsum[sidx] && !ddif[didx];

  assign sts.dead = over && (row == '0);
  assign sts.hit  = !over && safe && (NW'(row) == last_row);

  always_comb begin
    packed_place = '0;
    for (int i = 0; i < NPACK; i++) begin
      if (RW'(i) < row) begin
        packed_place[i*nqse_pkg::FIELD_W +: nqse_pkg::FIELD_W] =
          nqse_pkg::FIELD_W'(col_of[i]);
      end else if (RW'(i) == row) begin
        packed_place[i*nqse_pkg::FIELD_W +: nqse_pkg::FIELD_W] =
          nqse_pkg::FIELD_W'(cur_col);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      board_size <= nqse_pkg::BS_RESET;
      act_n      <= NW'(1);
      row        <= '0;
      cur_col    <= '0;
      cols       <= '0;
      dsum       <= '0;
      ddif       <= '0;
      count      <= '0;
    end else begin
      if (cfg_we) begin
        board_size <= cfg_board_size;
      end
      if (cmd.start) begin
        act_n   <= eff_n;
        row     <= '0;
        cur_col <= '0;
        cols    <= '0;
        dsum    <= '0;
        ddif    <= '0;
        count   <= '0;
      end else if (cmd.advance) begin
        cur_col <= cur_col + NW'(1);
      end else if (cmd.step) begin
        if (over) begin
          if (row != '0) begin
            row             <= prev_row;
            cur_col         <= prev_col + NW'(1);
            cols[prev_col]  <= 1'b0;
            dsum[psidx]     <= 1'b0;
            ddif[pdidx]     <= 1'b0;
          end
        end else if (safe) begin
          if (sts.hit) begin
            if (count != nqse_pkg::COUNT_MAX) begin
              count <= count + nqse_pkg::COUNT_W'(1);
            end
          end else begin
            row           <= row + RW'(1);
            cur_col       <= '0;
            cols[cur_col] <= 1'b1;
            dsum[sidx]    <= 1'b1;
            ddif[didx]    <= 1'b1;
          end
        end else begin
          cur_col <= cur_col + NW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && !over && safe && !sts.hit) begin
      col_of[row] <= cur_col;
    end
    if (cmd.load_out) begin
      rsp_found     <= cmd.res_found;
      rsp_placement <= cmd.res_found ? packed_place : '0;
      rsp_count     <= count;
    end
  end

  `NQSE_ASSERT_NOW(a_queens_match_row, 1'b1, $countones(cols) == int'(row))
  `NQSE_ASSERT_NOW(a_diag_match_row, 1'b1, $countones(dsum) == $countones(ddif))
  `NQSE_ASSERT_NEXT(a_start_clears, cmd.start, (count == '0) && (row == '0) && (cols == '0))
  `NQSE_ASSERT_NEXT(a_count_grows, !cmd.start, count >= $past(count))

endmodule

// File: sv/nqse_ctrl.sv
// Controller: transaction sequencing and search state machine.
`include "n_queens_solution_enumerator_top_macros.svh"

module nqse_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_restart,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output nqse_pkg::cmd_t cmd,
  input  nqse_pkg::sts_t sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_HOLD
  } state_t;

  state_t state;
  logic   started;
  logic   exhausted;
  logic   res_found;
  logic   in_acc;
  logic   new_search;

  assign in_ready   = (state == S_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign new_search = in_restart || !started;

  always_comb begin
    cmd           = '0;
    cmd.start     = in_acc && new_search;
    cmd.advance   = in_acc && !new_search && !exhausted;
    cmd.step      = (state == S_SEARCH);
    cmd.load_out  = (state == S_HOLD) && (!out_valid || out_ready);
    cmd.res_found = res_found;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      started   <= 1'b0;
      exhausted <= 1'b0;
      res_found <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (new_search) begin
              started   <= 1'b1;
              exhausted <= 1'b0;
              state     <= S_SEARCH;
            end else if (exhausted) begin
              res_found <= 1'b0;
              state     <= S_HOLD;
            end else begin
              state <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (sts.hit) begin
            res_found <= 1'b1;
            state     <= S_HOLD;
          end else if (sts.dead) begin
            res_found <= 1'b0;
            exhausted <= 1'b1;
            state     <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (cmd.load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `NQSE_ASSERT_NOW(a_exhausted_needs_start, exhausted, started)
  `NQSE_ASSERT_NEXT(a_one_at_a_time, in_acc, !in_ready)
  `NQSE_ASSERT_NEXT(a_dead_marks_exhausted, (state == S_SEARCH) && !sts.hit && sts.dead,
                    exhausted && !res_found)
  `NQSE_ASSERT_NEXT(a_load_shows_result, cmd.load_out, out_valid && in_ready)

endmodule
